// ----- src/cmslc_pkg.sv -----
package cmslc_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int HALF_LSB   = 1 << (FRAC_BITS - 1);

    localparam int OP_W       = 2;
    localparam int SAMPLE_W   = 15;
    localparam int KNOB_W     = 12;
    localparam int DUTY_W     = 8;
    localparam int SPEED_W    = 10;

    localparam int SMOOTH_W   = 8;
    localparam int THR_W      = 14;
    localparam int TILT_W     = 15;
    localparam int SLEW_W     = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam int FILT_W     = 24;
    localparam int FILT_X_W   = FILT_W + 1;
    localparam int DIFF_W     = FILT_W + 1;
    localparam int ACC_W      = DIFF_W + 1;
    localparam int WIDE_W     = 40;

    localparam int SQ_W       = FILT_W;
    localparam int SQP_W      = 2 * SQ_W;
    localparam int THR2_W     = 2 * (THR_W + FRAC_BITS);
    localparam int CMP_W      = (THR2_W > SQP_W + 2) ? THR2_W : SQP_W + 2;
    localparam int CMP_X_W    = CMP_W + 1;

    localparam int DIV_NUM_W  = 22;
    localparam int DIV_Q_W    = 10;
    localparam int DIV_D_W    = 12;

    localparam int CNT_W      = $clog2(SQ_W);

    localparam int SPEED_MAX  = 1000;
    localparam int KNOB_FULL  = 4095;
    localparam int KNOB_SCALE = 1000;
    localparam int KNOB_ROUND = 2047;
    localparam int PCT_ROUND  = 5;
    localparam int PCT_DIV    = 10;
    localparam int DUTY_SCALE = 255;
    localparam int DUTY_DIV   = 100;
    localparam int DUTY_MAX   = 255;

    localparam int RST_SMOOTHING = 205;
    localparam int RST_CRASH_THR = 2500;
    localparam int RST_TILT_THR  = 200;
    localparam int RST_SLEW      = 20;
    localparam int RST_DEADBAND  = 8;
    localparam int RST_MIN_START = 12;

    typedef enum logic [OP_W-1:0] {
        OP_ACCEL = 2'd0,
        OP_TICK  = 2'd1,
        OP_KNOB  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING = 3'd0,
        REG_CRASH_THR = 3'd1,
        REG_TILT_THR  = 3'd2,
        REG_SLEW      = 3'd3,
        REG_DEADBAND  = 3'd4,
        REG_MIN_START = 3'd5,
        REG_INVERT    = 3'd6
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMA,
        ST_EMA_END,
        ST_SQ_LOAD,
        ST_SQ,
        ST_CMP_SUM,
        ST_CMP_DEC,
        ST_SLEW,
        ST_PCT_LOAD,
        ST_DIV_PCT,
        ST_DUTY_LOAD,
        ST_DIV_DUTY,
        ST_DUTY_SET,
        ST_DIV_KNOB,
        ST_KNOB_SET,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } ema_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
    } seq_ctrl_t;

    function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = {{(WIDE_W-FILT_W+1){1'b0}}, {(FILT_W-1){1'b1}}};
        lo = {{(WIDE_W-FILT_W+1){1'b1}}, {(FILT_W-1){1'b0}}};
        if (v > hi)
            return hi[FILT_W-1:0];
        else if (v < lo)
            return lo[FILT_W-1:0];
        else
            return v[FILT_W-1:0];
    endfunction

    // Round half up to whole milli-g, keep the low field bits.
    function automatic logic [SAMPLE_W-1:0] to_mg(input logic signed [FILT_W-1:0] f);
        logic signed [FILT_X_W-1:0] t;
        logic signed [FILT_X_W-1:0] s;
        t = FILT_X_W'(f) + FILT_X_W'(HALF_LSB);
        s = t >>> FRAC_BITS;
        return s[SAMPLE_W-1:0];
    endfunction

endpackage

// ----- src/cmslc_in_if.sv -----
interface cmslc_in_if;
    import cmslc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic [KNOB_W-1:0]          knob_raw;

    modport source (output valid, op, accel_x, accel_y, accel_z, knob_raw, input ready);
    modport sink (input valid, op, accel_x, accel_y, accel_z, knob_raw, output ready);
endinterface

// ----- src/cmslc_out_if.sv -----
interface cmslc_out_if;
    import cmslc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [DUTY_W-1:0]          duty;
    logic                       motor_run;
    logic                       crashed;
    logic [SPEED_W-1:0]         speed_now;
    logic signed [SAMPLE_W-1:0] smooth_x;
    logic signed [SAMPLE_W-1:0] smooth_y;
    logic signed [SAMPLE_W-1:0] smooth_z;

    modport source (output valid, duty, motor_run, crashed, speed_now,
                    smooth_x, smooth_y, smooth_z, input ready);
    modport sink (input valid, duty, motor_run, crashed, speed_now,
                  smooth_x, smooth_y, smooth_z, output ready);
endinterface

// ----- src/cmslc_ema.sv -----
module cmslc_ema (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cmslc_pkg::ema_ctrl_t                 ctrl,
    input  logic [cmslc_pkg::SMOOTH_W-1:0]       alpha,
    input  logic signed [cmslc_pkg::SAMPLE_W-1:0] sample,
    output logic signed [cmslc_pkg::FILT_W-1:0]  filt
);
    import cmslc_pkg::*;

    logic signed [FILT_W-1:0] filt_reg;
    logic signed [FILT_W-1:0] filt_next;
    logic signed [FILT_W-1:0] in_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [SMOOTH_W-1:0]      alpha_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [SMOOTH_W-1:0]      frac_reg;

    logic signed [WIDE_W-1:0] sample_wide;
    logic signed [FILT_W-1:0] in_sat;
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  partial;
    logic signed [WIDE_W-1:0] round_wide;
    logic signed [WIDE_W-1:0] sum_wide;

    // new = in + round((old - in) * alpha / 256); the multiply runs one bit of alpha a cycle
    always_comb
    begin
        sample_wide = WIDE_W'(sample);
        in_sat      = sat_filt(sample_wide <<< FRAC_BITS);
        diff        = DIFF_W'(filt_reg) - DIFF_W'(in_sat);
        addend      = alpha_reg[0] ? ACC_W'(diff_reg) : ACC_W'(0);
        partial     = acc_reg + addend;
        round_wide  = WIDE_W'(signed'({1'b0, frac_reg[SMOOTH_W-1]}));
        sum_wide    = WIDE_W'(in_reg) + WIDE_W'(acc_reg) + round_wide;
        filt_next   = sat_filt(sum_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            filt_reg <= '0;
        else if (ctrl.commit)
            filt_reg <= filt_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            in_reg    <= in_sat;
            diff_reg  <= diff;
            alpha_reg <= alpha;
            acc_reg   <= '0;
            frac_reg  <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg   <= partial >>> 1;
            frac_reg  <= {partial[0], frac_reg[SMOOTH_W-1:1]};
            alpha_reg <= alpha_reg >> 1;
        end
    end

    assign filt = filt_reg;

endmodule

// ----- src/cmslc_sq.sv -----
module cmslc_sq (
    input  logic                           clk,
    input  cmslc_pkg::seq_ctrl_t           ctrl,
    input  logic [cmslc_pkg::SQ_W-1:0]     operand,
    output logic [cmslc_pkg::SQP_W-1:0]    product
);
    import cmslc_pkg::*;

    logic [SQ_W-1:0] mcand_reg;
    logic [SQ_W-1:0] mplier_reg;
    logic [SQ_W-1:0] acc_reg;
    logic [SQ_W:0]   partial;

    // Shift-add: multiplier bits leave at the bottom, product low bits enter at the top
    always_comb
    begin
        partial = {1'b0, acc_reg} + (mplier_reg[0] ? {1'b0, mcand_reg} : (SQ_W+1)'(0));
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg  <= operand;
            mplier_reg <= operand;
            acc_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            acc_reg    <= partial[SQ_W:1];
            mplier_reg <= {partial[0], mplier_reg[SQ_W-1:1]};
        end
    end

    assign product = {acc_reg, mplier_reg};

endmodule

// ----- src/cmslc_div.sv -----
module cmslc_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmslc_pkg::seq_ctrl_t             ctrl,
    input  logic [cmslc_pkg::DIV_NUM_W-1:0]  num,
    input  logic [cmslc_pkg::DIV_D_W-1:0]    den,
    output logic [cmslc_pkg::DIV_Q_W-1:0]    quo
);
    import cmslc_pkg::*;

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_Q_W-1:0] quo_reg;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               fits;

    // Restoring division: numerator bits shift out of quo_reg as quotient bits shift in.
    // The top of the numerator must already be below the divisor.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_Q_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= num[DIV_NUM_W-1:DIV_Q_W];
            quo_reg <= num[DIV_Q_W-1:0];
            den_reg <= den;
        end
        else if (ctrl.step)
        begin
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign quo = quo_reg;

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.step |=> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

endmodule

// ----- src/crash_latched_motor_slew_control.sv -----
// Crash-latched motor slew controller.
//
// cmd carries one request per valid/ready handshake: op selects an accel
// sample, a motor tick, a knob sample or a crash clear. status returns one
// result per request with the held duty, run flag, crash latch, present
// speed and the three smoothed accelerations in milli-g.
// cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle.
//
// One request is worked on at a time. An accel sample runs the serial
// smoother multiply, the serial squarers and the compare; a motor tick runs
// two serial divisions, or goes straight to the result when crashed; a knob
// sample runs one division; a clear goes straight to the result.
// The result is held in an output register, so the next request is taken
// while a result still waits; if status stalls, the following request stops
// at its final state until the output register frees.
// Reset clears the filters, crash latch, speeds, duty and run flag, empties
// the output register and restores the default register values.
module crash_latched_motor_slew_control (
    input  logic                               clk,
    input  logic                               rst_n,
    cmslc_in_if.sink                           cmd,
    cmslc_out_if.source                        status,
    input  logic                               cfg_we,
    input  logic [cmslc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cmslc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cmslc_pkg::*;

    // configuration
    logic [SMOOTH_W-1:0]      smooth_reg;
    logic [THR_W-1:0]         thr_reg;
    logic signed [TILT_W-1:0] tilt_reg;
    logic [SLEW_W-1:0]        slew_reg;
    logic [DUTY_W-1:0]        deadband_reg;
    logic [DUTY_W-1:0]        min_start_reg;
    logic                     invert_reg;

    // control and state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                crash_reg, crash_next;
    logic [SPEED_W-1:0]  target_reg, target_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic [DUTY_W-1:0]   duty_reg, duty_next;
    logic                run_reg, run_next;
    logic                out_valid_reg, out_valid_next;

    logic [DUTY_W-1:0]          out_duty_reg;
    logic                       out_run_reg;
    logic                       out_crash_reg;
    logic [SPEED_W-1:0]         out_speed_reg;
    logic signed [SAMPLE_W-1:0] out_x_reg;
    logic signed [SAMPLE_W-1:0] out_y_reg;
    logic signed [SAMPLE_W-1:0] out_z_reg;

    logic [CMP_W-1:0]           sxy_reg;
    logic signed [CMP_X_W-1:0]  rest_reg;

    ema_ctrl_t           ema_ctrl;
    seq_ctrl_t           sq_ctrl;
    seq_ctrl_t           div_ctrl;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_D_W-1:0]  div_den;
    logic [DIV_Q_W-1:0]  div_quo;
    logic                out_load;
    logic                sum_load;
    logic                accept;

    logic signed [FILT_W-1:0] filt_x, filt_y, filt_z;
    logic [SQ_W-1:0]     mag_x, mag_y, mag_z;
    logic [SQP_W-1:0]    prod_x, prod_y, prod_z, prod_t;
    logic [CMP_W-1:0]    thr2;
    logic                mag_hit;
    logic                tilt_hit;
    logic signed [WIDE_W-1:0] fy_wide, tilt_wide;

    logic [KNOB_W-1:0]    knob_eff;
    logic [DIV_NUM_W-1:0] knob_num;
    logic [SPEED_W:0]     up_sum;
    logic [SPEED_W-1:0]   gap;
    logic [SPEED_W-1:0]   slew_val;
    logic [DUTY_W-1:0]    duty_raw;

    cmslc_ema u_ema_x (.clk(clk), .rst_n(rst_n), .ctrl(ema_ctrl), .alpha(smooth_reg),
                       .sample(cmd.accel_x), .filt(filt_x));
    cmslc_ema u_ema_y (.clk(clk), .rst_n(rst_n), .ctrl(ema_ctrl), .alpha(smooth_reg),
                       .sample(cmd.accel_y), .filt(filt_y));
    cmslc_ema u_ema_z (.clk(clk), .rst_n(rst_n), .ctrl(ema_ctrl), .alpha(smooth_reg),
                       .sample(cmd.accel_z), .filt(filt_z));

    assign mag_x = filt_x[FILT_W-1] ? SQ_W'(-filt_x) : SQ_W'(filt_x);
    assign mag_y = filt_y[FILT_W-1] ? SQ_W'(-filt_y) : SQ_W'(filt_y);
    assign mag_z = filt_z[FILT_W-1] ? SQ_W'(-filt_z) : SQ_W'(filt_z);

    cmslc_sq u_sq_x (.clk(clk), .ctrl(sq_ctrl), .operand(mag_x), .product(prod_x));
    cmslc_sq u_sq_y (.clk(clk), .ctrl(sq_ctrl), .operand(mag_y), .product(prod_y));
    cmslc_sq u_sq_z (.clk(clk), .ctrl(sq_ctrl), .operand(mag_z), .product(prod_z));
    cmslc_sq u_sq_t (.clk(clk), .ctrl(sq_ctrl), .operand(SQ_W'(thr_reg)), .product(prod_t));

    cmslc_div u_div (.clk(clk), .rst_n(rst_n), .ctrl(div_ctrl), .num(div_num),
                     .den(div_den), .quo(div_quo));

    // Threshold is squared unscaled, then moved up by both fraction shifts
    assign thr2      = CMP_W'(prod_t) << (2 * FRAC_BITS);
    assign mag_hit   = signed'({1'b0, sxy_reg}) >= rest_reg;
    assign fy_wide   = WIDE_W'(filt_y);
    assign tilt_wide = WIDE_W'(tilt_reg) <<< FRAC_BITS;
    assign tilt_hit  = fy_wide > tilt_wide;

    assign knob_eff = invert_reg ? KNOB_W'(KNOB_FULL) - cmd.knob_raw : cmd.knob_raw;
    assign knob_num = DIV_NUM_W'(knob_eff) * DIV_NUM_W'(KNOB_SCALE) + DIV_NUM_W'(KNOB_ROUND);

    always_comb
    begin
        up_sum   = {1'b0, speed_reg} + (SPEED_W+1)'(slew_reg);
        gap      = speed_reg - target_reg;
        slew_val = speed_reg;
        if (speed_reg < target_reg)
            slew_val = (up_sum > {1'b0, target_reg}) ? target_reg : up_sum[SPEED_W-1:0];
        else if (speed_reg > target_reg)
            slew_val = (gap > SPEED_W'(slew_reg)) ? speed_reg - SPEED_W'(slew_reg)
                                                  : target_reg;
        duty_raw = (div_quo > DIV_Q_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : div_quo[DUTY_W-1:0];
    end

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        crash_next     = crash_reg;
        target_next    = target_reg;
        speed_next     = speed_reg;
        duty_next      = duty_reg;
        run_next       = run_reg;
        ema_ctrl       = '0;
        sq_ctrl        = '0;
        div_ctrl       = '0;
        div_num        = knob_num;
        div_den        = DIV_D_W'(KNOB_FULL);
        sum_load       = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    unique case (op_t'(cmd.op))
                        OP_ACCEL:
                        begin
                            ema_ctrl.load = 1'b1;
                            state_next    = ST_EMA;
                        end
                        OP_TICK:
                            state_next = ST_SLEW;
                        OP_KNOB:
                        begin
                            div_ctrl.load = 1'b1;
                            state_next    = ST_DIV_KNOB;
                        end
                        OP_CLEAR:
                        begin
                            crash_next = 1'b0;
                            state_next = ST_DONE;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMA:
            begin
                ema_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SMOOTH_W - 1))
                    state_next = ST_EMA_END;
            end
            ST_EMA_END:
            begin
                ema_ctrl.commit = 1'b1;
                state_next      = ST_SQ_LOAD;
            end
            ST_SQ_LOAD:
            begin
                sq_ctrl.load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SQ;
            end
            ST_SQ:
            begin
                sq_ctrl.step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQ_W - 1))
                    state_next = ST_CMP_SUM;
            end
            ST_CMP_SUM:
            begin
                sum_load   = 1'b1;
                state_next = ST_CMP_DEC;
            end
            ST_CMP_DEC:
            begin
                if (mag_hit || tilt_hit)
                    crash_next = 1'b1;
                state_next = ST_DONE;
            end
            ST_SLEW:
            begin
                if (crash_reg)
                begin
                    speed_next = '0;
                    duty_next  = '0;
                    run_next   = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    speed_next = slew_val;
                    state_next = ST_PCT_LOAD;
                end
            end
            ST_PCT_LOAD:
            begin
                div_ctrl.load = 1'b1;
                div_num       = DIV_NUM_W'(speed_reg) + DIV_NUM_W'(PCT_ROUND);
                div_den       = DIV_D_W'(PCT_DIV);
                cnt_next      = '0;
                state_next    = ST_DIV_PCT;
            end
            ST_DIV_PCT:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_Q_W - 1))
                    state_next = ST_DUTY_LOAD;
            end
            ST_DUTY_LOAD:
            begin
                div_ctrl.load = 1'b1;
                div_num       = DIV_NUM_W'(div_quo) * DIV_NUM_W'(DUTY_SCALE);
                div_den       = DIV_D_W'(DUTY_DIV);
                cnt_next      = '0;
                state_next    = ST_DIV_DUTY;
            end
            ST_DIV_DUTY:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_Q_W - 1))
                    state_next = ST_DUTY_SET;
            end
            ST_DUTY_SET:
            begin
                if (duty_raw <= deadband_reg)
                begin
                    duty_next = '0;
                    run_next  = 1'b0;
                end
                else
                begin
                    duty_next = (duty_raw < min_start_reg) ? min_start_reg : duty_raw;
                    run_next  = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DIV_KNOB:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_Q_W - 1))
                    state_next = ST_KNOB_SET;
            end
            ST_KNOB_SET:
            begin
                target_next = SPEED_W'(div_quo);
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register frees
                if (!out_valid_reg || status.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (status.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            crash_reg     <= 1'b0;
            target_reg    <= '0;
            speed_reg     <= '0;
            duty_reg      <= '0;
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            crash_reg     <= crash_next;
            target_reg    <= target_next;
            speed_reg     <= speed_next;
            duty_reg      <= duty_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg    <= SMOOTH_W'(RST_SMOOTHING);
            thr_reg       <= THR_W'(RST_CRASH_THR);
            tilt_reg      <= TILT_W'(RST_TILT_THR);
            slew_reg      <= SLEW_W'(RST_SLEW);
            deadband_reg  <= DUTY_W'(RST_DEADBAND);
            min_start_reg <= DUTY_W'(RST_MIN_START);
            invert_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SMOOTHING: smooth_reg    <= cfg_data[SMOOTH_W-1:0];
                REG_CRASH_THR: thr_reg       <= cfg_data[THR_W-1:0];
                REG_TILT_THR:  tilt_reg      <= cfg_data[TILT_W-1:0];
                REG_SLEW:      slew_reg      <= cfg_data[SLEW_W-1:0];
                REG_DEADBAND:  deadband_reg  <= cfg_data[DUTY_W-1:0];
                REG_MIN_START: min_start_reg <= cfg_data[DUTY_W-1:0];
                REG_INVERT:    invert_reg    <= cfg_data[0];
                default:       invert_reg    <= invert_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_load)
        begin
            sxy_reg  <= CMP_W'(prod_x) + CMP_W'(prod_y);
            rest_reg <= signed'(CMP_X_W'(thr2)) - signed'(CMP_X_W'(prod_z));
        end
        if (out_load)
        begin
            out_duty_reg  <= duty_reg;
            out_run_reg   <= run_reg;
            out_crash_reg <= crash_reg;
            out_speed_reg <= speed_reg;
            out_x_reg     <= to_mg(filt_x);
            out_y_reg     <= to_mg(filt_y);
            out_z_reg     <= to_mg(filt_z);
        end
    end

    assign status.valid     = out_valid_reg;
    assign status.duty      = out_duty_reg;
    assign status.motor_run = out_run_reg;
    assign status.crashed   = out_crash_reg;
    assign status.speed_now = out_speed_reg;
    assign status.smooth_x  = out_x_reg;
    assign status.smooth_y  = out_y_reg;
    assign status.smooth_z  = out_z_reg;

    a_clear_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.op == OP_CLEAR) |=> !crash_reg)
        else $error("crash latch still set after clear");

    a_speed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= SPEED_W'(SPEED_MAX))
        else $error("present speed above full scale");

    a_run_matches_duty: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg == (duty_reg != '0))
        else $error("run flag disagrees with held duty");

    a_crash_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLEW && crash_reg) |=> (speed_reg == '0 && !run_reg))
        else $error("tick while crashed left the motor running");

endmodule
